>>> src/rep_pkg.sv
package rep_pkg;

  localparam int MaxRows = 4;
  localparam int MaxCols = 8;
  localparam int QOne = 65536;
  localparam int ThreshW = 31;
  localparam int RowsCfgW = 3;
  localparam int ColsCfgW = 4;
  localparam int CfgDataW = 31;
  localparam int CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ZERO_THRESHOLD = 2'd0,
    REG_ROWS_IN_USE    = 2'd1,
    REG_COLS_IN_USE    = 2'd2,
    REG_UNUSED         = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] element_value;
    logic               last_element;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         result_row;
    logic [2:0]         result_col;
    logic               result_last;
  } out_item_t;

  // Divider handshake between sequencer and divider
  typedef struct packed {
    logic        go;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic signed [31:0] quo;
  } div_rsp_t;

  // Saturate a 64-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh7FFFFFFF) r = 32'sh7FFFFFFF;
    else if (v < -64'sh80000000) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

>>> src/rep_ram.sv
module rep_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

>>> src/rep_div.sv
module rep_div import rep_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  // Restoring divider, one quotient bit per cycle: |num|*2^16 / |den|
  logic [47:0] dividend;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic        neg;
  logic [5:0]  cnt;
  logic        busy;
  logic [33:0] trial;
  logic signed [63:0] qs;
  logic        done_q;
  logic signed [31:0] quo_c;

  assign trial = {rem, dividend[47]} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req.go) begin
        busy <= 1'b1;
        cnt <= 6'd48;
        rem <= '0;
        neg <= req.num[31] ^ req.den[31];
        dividend <= {(req.num[31] ? 32'(-req.num) : 32'(req.num)), 16'h0};
        dvs <= req.den[31] ? 32'(-req.den) : 32'(req.den);
      end else if (busy) begin
        if (!trial[33]) begin
          rem <= trial[32:0];
          dividend <= {dividend[46:0], 1'b1};
        end else begin
          rem <= {rem[31:0], dividend[47]};
          dividend <= {dividend[46:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    qs = neg ? -$signed({16'h0, dividend}) : $signed({16'h0, dividend});
    quo_c = sat32(qs);
  end

  assign rsp = {done_q, quo_c};

endmodule

>>> src/row_echelon_partial_pivot.sv
// Sequence: elements load while start is high; after the last element the
// reduction (pivot search, row swap, divide pass, update of the rows below)
// runs on one RAM with a read and a write port, then one result per cycle.
// Throughput: one matrix at a time; start is refused while busy is high.
// Reset: synchronous active-high rst clears control and sets registers to
// defaults; matrix storage is not cleared. The receiver cannot stall.
module row_echelon_partial_pivot import rep_pkg::*; #(
  parameter int MAX_ROWS = MaxRows,
  parameter int MAX_COLS = MaxCols
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  in_item_t            in_item,
  output logic                result_strobe,
  output out_item_t           result,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW = RW + CW;
  localparam int Depth = 1 << AW;

  typedef enum logic [13:0] {
    S_LOAD  = 14'b00000000000001,
    S_PRD   = 14'b00000000000010,
    S_PSCAN = 14'b00000000000100,
    S_PDEC  = 14'b00000000001000,
    S_SWR   = 14'b00000000010000,
    S_SWW   = 14'b00000000100000,
    S_DRD   = 14'b00000001000000,
    S_DWAIT = 14'b00000010000000,
    S_FRD   = 14'b00000100000000,
    S_ERD   = 14'b00001000000000,
    S_EMUL  = 14'b00010000000000,
    S_EWR   = 14'b00100000000000,
    S_ORD   = 14'b01000000000000,
    S_NEXT  = 14'b10000000000000
  } state_t;

  state_t state;

  // configuration
  logic [ThreshW-1:0]  zero_threshold;
  logic [RowsCfgW-1:0] rows_in_use;
  logic [ColsCfgW-1:0] cols_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_threshold <= ThreshW'(1);
      rows_in_use <= RowsCfgW'(3);
      cols_in_use <= ColsCfgW'(7);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ZERO_THRESHOLD: zero_threshold <= cfg_data[ThreshW-1:0];
        REG_ROWS_IN_USE:    rows_in_use <= cfg_data[RowsCfgW-1:0];
        REG_COLS_IN_USE:    cols_in_use <= cfg_data[ColsCfgW-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes, value N-1 kept in RW/CW bits
  logic [RW-1:0] nr_m1;
  logic [CW-1:0] nc_m1;
  always_comb begin
    if (rows_in_use == '0) nr_m1 = '0;
    else if (32'(rows_in_use) > MAX_ROWS) nr_m1 = RW'(MAX_ROWS - 1);
    else nr_m1 = RW'(32'(rows_in_use) - 1);
    if (cols_in_use == '0) nc_m1 = '0;
    else if (32'(cols_in_use) > MAX_COLS) nc_m1 = CW'(MAX_COLS - 1);
    else nc_m1 = CW'(32'(cols_in_use) - 1);
  end

  // memory
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  rep_ram #(.Width(32), .Depth(Depth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  div_req_t dreq;
  div_rsp_t drsp;
  rep_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // sequencer registers
  logic [RW-1:0] lrow, prow, irow, brow;
  logic [CW-1:0] lcol, pcol, jcol;
  logic          lfull;
  logic [32:0]   bmag;
  logic signed [31:0] piv, fac, elem;
  logic signed [63:0] prod;
  logic          rd_pend, swap_ph;

  logic signed [31:0] rsv;
  logic [32:0] rmag;
  logic signed [63:0] prod_tz;
  assign rsv = rdata;
  assign rmag = rsv[31] ? 33'(-$signed({rsv[31], rsv})) : {1'b0, rsv};
  // product scaled back to Q16.16, truncated toward zero
  assign prod_tz = (prod + (prod[63] ? 64'sd65535 : 64'sd0)) >>> 16;

  assign busy = (state != S_LOAD);

  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    dreq = '0;
    unique case (state)
      S_LOAD: begin
        we = start && !lfull;
        waddr = {lrow, lcol};
        wdata = in_item.element_value;
      end
      S_PRD, S_PSCAN: raddr = {irow, pcol};
      S_SWR: raddr = {prow, jcol};
      // RAM is read-first: brow is read while it takes the prow word
      S_SWW: begin
        we = 1'b1;
        waddr = swap_ph ? {prow, jcol} : {brow, jcol};
        wdata = rdata;
        raddr = {brow, jcol};
      end
      S_DRD: raddr = {prow, jcol};
      S_DWAIT: begin
        dreq.go = rd_pend;
        dreq.num = rsv;
        dreq.den = piv;
        we = drsp.done;
        waddr = {prow, jcol};
        wdata = drsp.quo;
      end
      S_FRD: raddr = {irow, pcol};
      S_ERD: raddr = rd_pend ? {irow, jcol} : {prow, jcol};
      S_EWR: begin
        we = 1'b1;
        waddr = {irow, jcol};
        wdata = (jcol == pcol) ? 32'sd0 :
                sat32(64'(elem) - 64'(sat32(prod_tz)));
      end
      S_ORD: raddr = {irow, jcol};
      default: ;
    endcase
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      lrow <= '0;
      lcol <= '0;
      lfull <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: if (start) begin
          if (!lfull) begin
            if (lcol == nc_m1) begin
              lcol <= '0;
              if (lrow == nr_m1) lfull <= 1'b1;
              else lrow <= lrow + RW'(1);
            end else lcol <= lcol + CW'(1);
          end
          if (in_item.last_element) begin
            prow <= '0;
            pcol <= '0;
            irow <= '0;
            state <= S_PRD;
          end
        end
        // pivot search over column pcol, rows prow..nr-1
        S_PRD: begin
          bmag <= '0;
          brow <= prow;
          state <= S_PSCAN;
          irow <= irow + RW'(1);
        end
        S_PSCAN: begin
          if (rmag > bmag) begin
            bmag <= rmag;
            brow <= irow - RW'(1);
          end
          if (irow - RW'(1) == nr_m1) state <= S_PDEC;
          else irow <= irow + RW'(1);
        end
        S_PDEC: begin
          jcol <= '0;
          rd_pend <= 1'b0;
          swap_ph <= 1'b0;
          if (bmag == '0 || bmag < {2'b00, zero_threshold}) state <= S_NEXT;
          else if (brow != prow) state <= S_SWR;
          else state <= S_DRD;
        end
        // swap whole rows: read prow, write brow<-prow word, write prow<-brow word
        S_SWR: begin
          state <= S_SWW;
        end
        S_SWW: begin
          if (!swap_ph) begin
            swap_ph <= 1'b1;
          end else begin
            swap_ph <= 1'b0;
            if (jcol == CW'(MAX_COLS - 1)) begin
              jcol <= '0;
              state <= S_DRD;
            end else begin
              jcol <= jcol + CW'(1);
              state <= S_SWR;
            end
          end
        end
        // divide pass over the pivot row
        S_DRD: begin
          rd_pend <= 1'b1;
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          rd_pend <= 1'b0;
          if (drsp.done) begin
            if (jcol == nc_m1) begin
              irow <= prow + RW'(1);
              state <= (prow == nr_m1) ? S_NEXT : S_FRD;
            end else begin
              jcol <= jcol + CW'(1);
              state <= S_DRD;
            end
          end
        end
        S_FRD: begin
          jcol <= '0;
          rd_pend <= 1'b0;
          state <= S_ERD;
        end
        S_ERD: begin
          if (!rd_pend) begin
            if (jcol == '0) fac <= rsv;
            rd_pend <= 1'b1;
          end else begin
            prod <= 64'(fac) * 64'(rsv);
            rd_pend <= 1'b0;
            state <= S_EMUL;
          end
        end
        S_EMUL: begin
          elem <= rsv;
          state <= S_EWR;
        end
        S_EWR: begin
          if (jcol == nc_m1) begin
            jcol <= '0;
            if (irow == nr_m1) state <= S_NEXT;
            else begin
              irow <= irow + RW'(1);
              state <= S_FRD;
            end
          end else begin
            jcol <= jcol + CW'(1);
            state <= S_ERD;
          end
        end
        S_NEXT: begin
          if (pcol == nc_m1 || (bmag != '0 && bmag >= {2'b00, zero_threshold}
              && prow == nr_m1)) begin
            irow <= '0;
            jcol <= '0;
            rd_pend <= 1'b0;
            state <= S_ORD;
          end else begin
            if (bmag != '0 && bmag >= {2'b00, zero_threshold})
              prow <= prow + RW'(1);
            pcol <= pcol + CW'(1);
            irow <= (bmag != '0 && bmag >= {2'b00, zero_threshold}) ?
                    prow + RW'(1) : prow;
            state <= S_PRD;
          end
        end
        S_ORD: begin
          if (irow == nr_m1 && jcol == nc_m1) begin
            state <= S_LOAD;
            lrow <= '0;
            lcol <= '0;
            lfull <= 1'b0;
            irow <= '0;
            jcol <= '0;
          end else if (jcol == nc_m1) begin
            jcol <= '0;
            irow <= irow + RW'(1);
          end else jcol <= jcol + CW'(1);
        end
        default: state <= S_LOAD;
      endcase
      // pivot value follows the running maximum of the scan
      if (state == S_PSCAN && rmag > bmag) piv <= rsv;
      if (state == S_PSCAN && irow - RW'(1) == prow && !(rmag > bmag)) piv <= rsv;
    end
  end

  // output metadata is registered in step with the memory read data
  logic [1:0] out_row;
  logic [2:0] out_col;
  logic       out_last;
  logic       emit_q;
  always_ff @(posedge clk) begin
    if (rst) emit_q <= 1'b0;
    else emit_q <= (state == S_ORD);
    out_row <= 2'(irow);
    out_col <= 3'(jcol);
    out_last <= (irow == nr_m1) && (jcol == nc_m1);
  end

  // result ports: value from memory arrives in the cycle after its address
  assign result_strobe = emit_q;
  assign result = {rsv, out_row, out_col, out_last};

  // Assertions
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !(we && state == S_LOAD)) else $error("write in load while busy");
  a_strobe_out: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(state == S_ORD)) else $error("strobe outside output");
  a_div_go: assert property (@(posedge clk) disable iff (rst)
    dreq.go |-> state == S_DWAIT) else $error("divide outside divide pass");

endmodule

>>> sim/row_echelon_partial_pivot_test.sv
`timescale 1ns / 1ps

module row_echelon_partial_pivot_test;
  import rep_pkg::*;

  localparam int TargetItems = 450;
  localparam int QuietTail = 60;
  localparam longint CycleLimit = 3_000_000;
  localparam int SettleCycles = 40;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  in_item_t in_item;
  logic result_strobe;
  out_item_t result;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  row_echelon_partial_pivot dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .result_strobe(result_strobe), .result(result), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: register copies and the matrix store
  logic [30:0] pivot_floor;
  logic [2:0] rows_reg;
  logic [3:0] cols_reg;
  int matrix [MaxRows][MaxCols];
  bit loaded [MaxRows][MaxCols];
  int load_pos;

  out_item_t reduced_q[$];
  int mismatches;
  int items_sent;
  int matrices_sent;
  int results_seen;
  int config_writes;
  longint cycle_count;

  typedef struct {
    logic [31:0] value;
    logic last;
    bit has_typed;
    logic [31:0] typed_first;
  } stim_row_t;

  stim_row_t directed [] = '{
    // extremes in a full 2x2 load
    '{32'h7FFFFFFF, 1'b0, 0, 0}, '{32'h80000000, 1'b0, 0, 0},
    '{32'h00000001, 1'b0, 0, 0}, '{32'hFFFFFFFF, 1'b1, 0, 0},
    // all-zero matrix: every pivot counts as zero
    '{32'h0, 1'b0, 0, 0}, '{32'h0, 1'b0, 0, 0},
    '{32'h0, 1'b0, 0, 0}, '{32'h0, 1'b1, 1, 32'h0},
    // plain case, first element normalizes to 1.0
    '{32'h00040000, 1'b0, 0, 0}, '{32'h00020000, 1'b0, 0, 0},
    '{32'h00010000, 1'b0, 0, 0}, '{32'h00010000, 1'b1, 1, 32'h00010000},
    // tiny pivot, quotient saturates
    '{32'h00000100, 1'b0, 0, 0}, '{32'h7FFFFFFF, 1'b0, 0, 0},
    '{32'h0, 1'b0, 0, 0}, '{32'h0, 1'b1, 1, 32'h00010000},
    // partial load, rest of the store kept
    '{32'h00030000, 1'b1, 1, 32'h00010000},
    // excess element ignored
    '{32'h1, 1'b0, 0, 0}, '{32'h2, 1'b0, 0, 0}, '{32'h3, 1'b0, 0, 0},
    '{32'h4, 1'b0, 0, 0}, '{32'h5, 1'b1, 0, 0},
    // negative pivot
    '{32'hFFFF0000, 1'b0, 0, 0}, '{32'h00050000, 1'b0, 0, 0},
    '{32'h00008000, 1'b0, 0, 0}, '{32'h00000001, 1'b1, 1, 32'h00010000}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clamp_q(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic int active_rows();
    if (rows_reg == 0) return 1;
    return (rows_reg > MaxRows) ? MaxRows : int'(rows_reg);
  endfunction

  function automatic int active_cols();
    if (cols_reg == 0) return 1;
    return (cols_reg > MaxCols) ? MaxCols : int'(cols_reg);
  endfunction

  function automatic longint magnitude(int v);
    longint w;
    w = v;
    return (w < 0) ? -w : w;
  endfunction

  // Gaussian elimination with partial pivoting on the predictor's store
  function automatic void eliminate(int nr, int nc);
    int row;
    int col;
    int best;
    longint best_mag;
    int piv;
    longint f;
    int prod;
    int tmp;
    bit tmp_flag;
    row = 0;
    col = 0;
    while (row < nr && col < nc) begin
      best = row;
      best_mag = magnitude(matrix[row][col]);
      for (int i = row; i < nr; i++) begin
        if (magnitude(matrix[i][col]) > best_mag) begin
          best = i;
          best_mag = magnitude(matrix[i][col]);
        end
      end
      if (best_mag == 0 || best_mag < longint'(pivot_floor)) begin
        col++;
        continue;
      end
      // whole rows move, written marks travel with them
      if (best != row) begin
        for (int j = 0; j < MaxCols; j++) begin
          tmp = matrix[row][j];
          matrix[row][j] = matrix[best][j];
          matrix[best][j] = tmp;
          tmp_flag = loaded[row][j];
          loaded[row][j] = loaded[best][j];
          loaded[best][j] = tmp_flag;
        end
      end
      piv = matrix[row][col];
      for (int j = 0; j < nc; j++)
        matrix[row][j] = clamp_q((longint'(matrix[row][j]) * QOne) / longint'(piv));
      for (int i = row + 1; i < nr; i++) begin
        f = matrix[i][col];
        for (int j = 0; j < nc; j++) begin
          prod = clamp_q((f * longint'(matrix[row][j])) / QOne);
          matrix[i][j] = clamp_q(longint'(matrix[i][j]) - longint'(prod));
        end
        matrix[i][col] = 0;
      end
      row++;
      col++;
    end
  endfunction

  // Load one accepted element; on last, reduce and queue the whole matrix
  function automatic void predict_element(in_item_t it);
    int nr;
    int nc;
    out_item_t o;
    nr = active_rows();
    nc = active_cols();
    if (load_pos < nr * nc) begin
      matrix[load_pos / nc][load_pos % nc] = it.element_value;
      loaded[load_pos / nc][load_pos % nc] = 1;
      load_pos++;
    end
    if (it.last_element) begin
      eliminate(nr, nc);
      for (int r = 0; r < nr; r++) begin
        for (int c = 0; c < nc; c++) begin
          o.result_value = matrix[r][c];
          o.result_row = r[1:0];
          o.result_col = c[2:0];
          o.result_last = (r == nr - 1 && c == nc - 1);
          reduced_q.push_back(o);
        end
      end
      load_pos = 0;
      matrices_sent++;
    end
  endfunction

  // Result checker; the receiver cannot stall so every strobe is a transaction
  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      results_seen++;
      if (reduced_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result);
      end else begin
        if (result !== reduced_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", reduced_q[0], result);
        end
        void'(reduced_q.pop_front());
      end
    end
  end

  // Run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ZERO_THRESHOLD: pivot_floor = data[30:0];
      REG_ROWS_IN_USE: rows_reg = data[2:0];
      REG_COLS_IN_USE: cols_reg = data[3:0];
      default: ;
    endcase
    config_writes++;
  endtask

  task automatic wait_idle();
    while (reduced_q.size() != 0 || busy) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Drive one transaction; returns once it is accepted and busy is low
  task automatic send(logic [31:0] value, logic last);
    in_item_t it;
    int gap;
    if (items_sent < TargetItems - QuietTail && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.element_value = value;
    it.last_element = last;
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_element(it);
    items_sent++;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'h7FFFFFFF;
      2: return 32'h80000000;
      3: return $urandom;
      4: return $urandom_range(0, 32'h7FFFF) - 32'h40000;
      5: return $urandom_range(0, 32'h1FF) - 32'h100;
      default: return $urandom_range(0, 32'h1FFFFFF) - 32'h1000000;
    endcase
  endfunction

  // One matrix: usually a full load, sometimes short or with extra elements
  task automatic send_matrix();
    int nr;
    int nc;
    int total;
    int count;
    bit gap_found;
    nr = active_rows();
    nc = active_cols();
    total = nr * nc;
    case ($urandom_range(0, 9))
      0: count = $urandom_range(1, total);
      1: count = total + $urandom_range(1, 4);
      default: count = total;
    endcase
    // a short load must not expose entries never written since reset
    if (count < total) begin
      gap_found = 0;
      for (int p = count; p < total; p++)
        if (!loaded[p / nc][p % nc]) gap_found = 1;
      if (gap_found) count = total;
    end
    for (int k = 0; k < count; k++) send(pick_value(), k == count - 1);
  endtask

  initial begin
    stim_row_t sr;
    int phase;
    int phase_items;
    logic [30:0] thr;
    rst = 1'b1;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = REG_ZERO_THRESHOLD;
    cfg_data = '0;
    mismatches = 0;
    items_sent = 0;
    matrices_sent = 0;
    results_seen = 0;
    config_writes = 0;
    cycle_count = 0;
    load_pos = 0;
    pivot_floor = 31'd1;
    rows_reg = 3'd3;
    cols_reg = 4'd7;
    foreach (loaded[r, c]) begin
      loaded[r][c] = 0;
      matrix[r][c] = 0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part on a 2x2 matrix
    write_reg(REG_ZERO_THRESHOLD, 31'd1);
    write_reg(REG_ROWS_IN_USE, 31'd2);
    write_reg(REG_COLS_IN_USE, 31'd2);
    foreach (directed[i]) begin
      sr = directed[i];
      send(sr.value, sr.last);
      if (sr.has_typed) begin
        if (reduced_q.size() < 4 || reduced_q[reduced_q.size() - 4].result_value !==
            sr.typed_first) begin
          mismatches++;
          if (mismatches <= 10)
            $display("directed row %0d: expected first value %h", i, sr.typed_first);
        end
      end
    end
    start <= 1'b0;

    // random phases, each under a new register setting
    phase = 0;
    while (items_sent < TargetItems) begin
      wait_idle();
      case (phase)
        0: begin thr = 31'd0; write_reg(REG_ROWS_IN_USE, 31'd4);
             write_reg(REG_COLS_IN_USE, 31'd8); end
        1: begin thr = 31'h7FFFFFFF; write_reg(REG_ROWS_IN_USE, 31'd1);
             write_reg(REG_COLS_IN_USE, 31'd1); end
        2: begin thr = 31'd1; write_reg(REG_ROWS_IN_USE, 31'd0);
             write_reg(REG_COLS_IN_USE, 31'd0); end
        3: begin thr = 31'h10000; write_reg(REG_ROWS_IN_USE, 31'd7);
             write_reg(REG_COLS_IN_USE, 31'd15); end
        default: begin
          case ($urandom_range(0, 3))
            0: thr = 31'd0;
            1: thr = 31'($urandom_range(0, 32'h20000));
            2: thr = 31'($urandom);
            default: thr = 31'd1;
          endcase
          write_reg(REG_ROWS_IN_USE, 31'($urandom_range(0, 7)));
          write_reg(REG_COLS_IN_USE, 31'($urandom_range(0, 15)));
        end
      endcase
      write_reg(REG_ZERO_THRESHOLD, thr);
      phase_items = 0;
      while (phase_items < 40 && items_sent < TargetItems) begin
        phase_items -= items_sent;
        send_matrix();
        phase_items += items_sent;
      end
      start <= 1'b0;
      phase++;
    end

    @(posedge clk);
    start <= 1'b0;
    wait_idle();
    $display("covered %0d elements in %0d matrices over %0d register settings",
             items_sent, matrices_sent, phase + 1);
    $display("checked %0d reduced elements, %0d register writes, %0d mismatches",
             results_seen, config_writes, mismatches);
    if (mismatches == 0 && reduced_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
